### hdl/pagerank_csr_iteration_defines.svh
// ----------------------------------------------------------------------------
// pagerank_csr_iteration_defines
// Assertion macros shared by the ranking block.
// ----------------------------------------------------------------------------
`ifndef PAGERANK_CSR_ITERATION_DEFINES_SVH
`define PAGERANK_CSR_ITERATION_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define PRC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define PRC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/prc_pkg.sv
// ----------------------------------------------------------------------------
// prc_pkg
// Types, codes and defaults of the CSR ranking block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package prc_pkg;

  // Default sizes
  localparam int MAX_VERTICES_DEF       = 1024;
  localparam int MAX_EDGES_DEF          = 8192;
  localparam int RANK_FRACTION_BITS_DEF = 24;

  // Fixed field widths
  localparam int IDX_W  = 13;
  localparam int VAL_W  = 14;
  localparam int RANK_W = 32;
  localparam int VTX_W  = 10;
  localparam int DAMP_W = 16;
  localparam int VCNT_W = 11;
  localparam int ITER_W = 8;
  localparam int CFG_IDX_W = 2;

  // Request modes
  localparam logic [1:0] MODE_LOAD_ROW  = 2'd0;
  localparam logic [1:0] MODE_LOAD_EDGE = 2'd1;
  localparam logic [1:0] MODE_RUN       = 2'd2;
  localparam logic [1:0] MODE_READ      = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DAMPING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VCOUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ITERS   = 2'd2;

  // Reset values
  localparam logic [DAMP_W-1:0] DAMPING_RST = 16'd55706;
  localparam logic [VCNT_W-1:0] VCOUNT_RST  = 11'd1;
  localparam logic [ITER_W-1:0] ITERS_RST   = 8'd1;

  typedef struct packed {
    logic [1:0]       mode;
    logic [IDX_W-1:0] index;
    logic [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [RANK_W-1:0] rank_value;
    logic [VTX_W-1:0]  vertex;
    logic              run_done;
  } rsp_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_READ,
    S_INIT_DIV,
    S_INIT_WAIT,
    S_TEL_WAIT,
    S_INIT_WR,
    S_P_START,
    S_OFF0,
    S_ROW,
    S_EREAD,
    S_ECHK,
    S_CONTRIB,
    S_DIVW,
    S_NEXT_I,
    S_MUL,
    S_WR,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

### hdl/prc_div.sv
// ----------------------------------------------------------------------------
// prc_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module prc_div
  import prc_pkg::*;
#(
  parameter int NUM_W = 32,
  parameter int DEN_W = 14
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  busy_o,
  output logic                  done_o,
  output logic [NUM_W-1:0]      quot_o
);

  localparam int CW = $clog2(NUM_W + 1);

  logic             busy_q, done_q;
  logic [CW-1:0]    cnt_q;
  logic [DEN_W-1:0] rem_q, den_q;
  logic [NUM_W-1:0] q_q;

  logic [DEN_W:0]   trial;
  logic             ge;

  // one shift-subtract step
  assign trial = {rem_q, q_q[NUM_W-1]};
  assign ge    = (trial >= {1'b0, den_q});

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q   <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      q_q   <= {q_q[NUM_W-2:0], ge};
      rem_q <= ge ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = q_q;

endmodule

`default_nettype wire

### hdl/pagerank_csr_iteration.sv
// ----------------------------------------------------------------------------
// pagerank_csr_iteration
// Gauss-Seidel PageRank over a graph held in CSR row offset and edge memories.
// ----------------------------------------------------------------------------
// A load request (row offset or edge target) gives no response. A read
// request does one rank memory read and then gives its response. A run
// request first does two serial divisions (initial rank and teleport) and
// the rank initialization of N vertices, then per sweep and per vertex p it
// walks every row i, fetching its end offset and scanning its edges (the scan
// of a row stops at the first edge to p), using the divider when row i feeds
// p, and per vertex it does the first row fetch, the damping multiply and the
// write back. The rank, row offset and edge memories each have one read port
// and bound the rate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "pagerank_csr_iteration_defines.svh"

module pagerank_csr_iteration
  import prc_pkg::*;
#(
  parameter int MAX_VERTICES       = MAX_VERTICES_DEF,
  parameter int MAX_EDGES          = MAX_EDGES_DEF,
  parameter int RANK_FRACTION_BITS = RANK_FRACTION_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [DAMP_W-1:0]    cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire req_t                 in_req_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output rsp_t                      out_rsp_o
);

  localparam int VW   = $clog2(MAX_VERTICES);
  localparam int NW   = VW + 1;
  localparam int RAW  = $clog2(MAX_VERTICES + 1);
  localparam int EAW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int OW   = $clog2(MAX_EDGES + 1);
  localparam int DW   = (OW > NW) ? OW : NW;
  localparam int PW   = RANK_W + DAMP_W;

  // configuration
  logic [DAMP_W-1:0] damping_q;
  logic [VCNT_W-1:0] vcount_q;
  logic [ITER_W-1:0] iters_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      damping_q <= DAMPING_RST;
      vcount_q  <= VCOUNT_RST;
      iters_q   <= ITERS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DAMPING: damping_q <= cfg_wdata_i;
        CFG_VCOUNT:  vcount_q  <= cfg_wdata_i[VCNT_W-1:0];
        CFG_ITERS:   iters_q   <= cfg_wdata_i[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  // state
  state_e            state_q, state_d;
  logic [NW-1:0]     n_q, n_d, p_q, p_d, i_q, i_d;
  logic [ITER_W-1:0] it_q, it_d;
  logic [OW-1:0]     start_q, start_d, end_q, end_d, j_q, j_d;
  logic [RANK_W-1:0] sum_q, sum_d, init_q, init_d, tel_q, tel_d;
  logic [PW-1:0]     prod_q, prod_d;
  logic              rd_oob_q, rd_oob_d;
  logic [VTX_W-1:0]  rd_vtx_q, rd_vtx_d;
  logic              out_valid_q, out_valid_d;
  rsp_t              out_q, out_d;

  // memories
  logic [VAL_W-1:0]  row_mem  [MAX_VERTICES+1];
  logic [VAL_W-1:0]  edge_mem [MAX_EDGES];
  logic [RANK_W-1:0] rank_mem [MAX_VERTICES];
  logic [VAL_W-1:0]  row_rd_q, edge_rd_q;
  logic [RANK_W-1:0] rank_rd_q;

  logic              row_we, row_re, edge_we, edge_re, rank_we, rank_re;
  logic [RAW-1:0]    row_waddr, row_raddr;
  logic [EAW-1:0]    edge_waddr, edge_raddr;
  logic [VW-1:0]     rank_waddr, rank_raddr;
  logic [RANK_W-1:0] rank_wdata;

  always_ff @(posedge clk_i) begin
    if (row_we) row_mem[row_waddr] <= in_req_i.value;
    if (row_re) row_rd_q <= row_mem[row_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (edge_we) edge_mem[edge_waddr] <= in_req_i.value;
    if (edge_re) edge_rd_q <= edge_mem[edge_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (rank_we) rank_mem[rank_waddr] <= rank_wdata;
    if (rank_re) rank_rd_q <= rank_mem[rank_raddr];
  end

  // divider shared by init, teleport and contributions
  logic              div_start, div_busy, div_done;
  logic [RANK_W-1:0] div_num, div_quot;
  logic [DW-1:0]     div_den;

  prc_div #(
    .NUM_W (RANK_W),
    .DEN_W (DW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // helpers
  logic          in_acc;
  logic [OW-1:0] row_clip;
  logic [RANK_W:0] sum_add, rank_new;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE) ||
                      (out_valid_q && (in_req_i.mode == MODE_RUN ||
                                       in_req_i.mode == MODE_READ));
  assign row_clip   = (32'(row_rd_q) > 32'(MAX_EDGES)) ? OW'(MAX_EDGES) : OW'(row_rd_q);
  assign sum_add    = {1'b0, sum_q} + {1'b0, div_quot};
  assign rank_new   = {1'b0, prod_q[PW-1:DAMP_W]} + {1'b0, tel_q};

  // next state and control
  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    p_d         = p_q;
    i_d         = i_q;
    it_d        = it_q;
    start_d     = start_q;
    end_d       = end_q;
    j_d         = j_q;
    sum_d       = sum_q;
    init_d      = init_q;
    tel_d       = tel_q;
    prod_d      = prod_q;
    rd_oob_d    = rd_oob_q;
    rd_vtx_d    = rd_vtx_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    row_we      = 1'b0;
    row_re      = 1'b0;
    edge_we     = 1'b0;
    edge_re     = 1'b0;
    rank_we     = 1'b0;
    rank_re     = 1'b0;
    row_waddr   = RAW'(in_req_i.index);
    row_raddr   = '0;
    edge_waddr  = EAW'(in_req_i.index);
    edge_raddr  = EAW'(j_q);
    rank_waddr  = VW'(p_q);
    rank_raddr  = VW'(i_q);
    rank_wdata  = init_q;
    div_start   = 1'b0;
    div_num     = init_q;
    div_den     = DW'(n_q);

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_req_i.mode)
            MODE_LOAD_ROW:
              row_we = (32'(in_req_i.index) <= 32'(MAX_VERTICES));
            MODE_LOAD_EDGE:
              edge_we = (32'(in_req_i.index) < 32'(MAX_EDGES));
            MODE_RUN: begin
              if (vcount_q == '0) n_d = NW'(1);
              else if (32'(vcount_q) > 32'(MAX_VERTICES)) n_d = NW'(MAX_VERTICES);
              else n_d = NW'(vcount_q);
              state_d = S_INIT_DIV;
            end
            MODE_READ: begin
              rank_re    = 1'b1;
              rank_raddr = VW'(in_req_i.index);
              rd_oob_d   = (32'(in_req_i.index) >= 32'(MAX_VERTICES));
              rd_vtx_d   = in_req_i.index[VTX_W-1:0];
              state_d    = S_READ;
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        out_valid_d      = 1'b1;
        out_d.rank_value = rd_oob_q ? '0 : rank_rd_q;
        out_d.vertex     = rd_vtx_q;
        out_d.run_done   = 1'b0;
        state_d          = S_IDLE;
      end
      // initial rank 2^F / N
      S_INIT_DIV: begin
        div_start = 1'b1;
        div_num   = RANK_W'(64'(1) << RANK_FRACTION_BITS);
        state_d   = S_INIT_WAIT;
      end
      // teleport ((1 - d) 2^F) / N
      S_INIT_WAIT: begin
        if (div_done) begin
          init_d    = div_quot;
          div_start = 1'b1;
          div_num   = RANK_W'(64'(17'h10000 - 17'(damping_q)) << (RANK_FRACTION_BITS - 16));
          state_d   = S_TEL_WAIT;
        end
      end
      S_TEL_WAIT: begin
        if (div_done) begin
          tel_d   = div_quot;
          p_d     = '0;
          state_d = S_INIT_WR;
        end
      end
      S_INIT_WR: begin
        rank_we = 1'b1;
        p_d     = p_q + NW'(1);
        if (p_q + NW'(1) == n_q) begin
          p_d     = '0;
          it_d    = '0;
          state_d = (iters_q == '0) ? S_DONE : S_P_START;
        end
      end
      // new vertex: clear sum, fetch first row start
      S_P_START: begin
        sum_d     = '0;
        i_d       = '0;
        row_re    = 1'b1;
        row_raddr = '0;
        state_d   = S_OFF0;
      end
      S_OFF0: begin
        start_d   = row_clip;
        row_re    = 1'b1;
        row_raddr = RAW'(32'(i_q) + 32'd1);
        state_d   = S_ROW;
      end
      S_ROW: begin
        end_d   = row_clip;
        j_d     = start_q;
        rank_re = 1'b1;
        state_d = (row_clip > start_q) ? S_EREAD : S_NEXT_I;
      end
      S_EREAD: begin
        edge_re = 1'b1;
        state_d = S_ECHK;
      end
      // stop at the first edge to p
      S_ECHK: begin
        j_d = j_q + OW'(1);
        if (32'(edge_rd_q) == 32'(p_q)) state_d = S_CONTRIB;
        else if (j_q + OW'(1) == end_q) state_d = S_NEXT_I;
        else state_d = S_EREAD;
      end
      // self edges never feed their own vertex
      S_CONTRIB: begin
        if (i_q != p_q) begin
          div_start = 1'b1;
          div_num   = rank_rd_q;
          div_den   = DW'(end_q - start_q);
          state_d   = S_DIVW;
        end else begin
          state_d = S_NEXT_I;
        end
      end
      S_DIVW: begin
        if (div_done) begin
          sum_d   = sum_add[RANK_W] ? '1 : sum_add[RANK_W-1:0];
          state_d = S_NEXT_I;
        end
      end
      S_NEXT_I: begin
        start_d = end_q;
        i_d     = i_q + NW'(1);
        if (i_q + NW'(1) == n_q) begin
          state_d = S_MUL;
        end else begin
          row_re    = 1'b1;
          row_raddr = RAW'(32'(i_q) + 32'd2);
          state_d   = S_ROW;
        end
      end
      S_MUL: begin
        prod_d  = PW'(sum_q) * PW'(damping_q);
        state_d = S_WR;
      end
      S_WR: begin
        rank_we    = 1'b1;
        rank_wdata = rank_new[RANK_W] ? '1 : rank_new[RANK_W-1:0];
        p_d        = p_q + NW'(1);
        state_d    = S_P_START;
        if (p_q + NW'(1) == n_q) begin
          p_d = '0;
          if (9'(it_q) + 9'd1 == 9'(iters_q)) state_d = S_DONE;
          else it_d = it_q + ITER_W'(1);
        end
      end
      S_DONE: begin
        out_valid_d      = 1'b1;
        out_d.rank_value = '0;
        out_d.vertex     = '0;
        out_d.run_done   = 1'b1;
        state_d          = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    n_q      <= n_d;
    p_q      <= p_d;
    i_q      <= i_d;
    it_q     <= it_d;
    start_q  <= start_d;
    end_q    <= end_d;
    j_q      <= j_d;
    sum_q    <= sum_d;
    init_q   <= init_d;
    tel_q    <= tel_d;
    prod_q   <= prod_d;
    rd_oob_q <= rd_oob_d;
    rd_vtx_q <= rd_vtx_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // checks
  `PRC_ASSERT_IMP(a_acc_idle, clk_i, rst_ni, in_acc, state_q == S_IDLE, "request taken while busy")
  `PRC_ASSERT_IMP(a_div_free, clk_i, rst_ni, div_start, !div_busy, "divider restarted while busy")
  `PRC_ASSERT_NXT(a_done_rsp, clk_i, rst_ni, state_q == S_DONE, out_valid_q && out_q.run_done, "run end lost")
  `PRC_ASSERT_IMP(a_no_clobber, clk_i, rst_ni, out_valid_q && out_stall_i, state_q != S_DONE && state_q != S_READ, "pending response overwritten")

endmodule

`default_nettype wire
